/* rtl/rgbhsv_pkg.sv */
// Shared constants and types for the RGB to HSV converter pipeline.
package rgbhsv_pkg;

  // Field widths.
  localparam int unsigned InW   = 18;
  localparam int unsigned ChanW = 16;

  // Long division geometry: 17 quotient bits, 19-bit divisor and remainder.
  localparam int unsigned QuoW = 17;
  localparam int unsigned DenW = 19;

  // Full-scale channel value.
  localparam logic [ChanW-1:0] ChanMax = 16'hFFFF;

  // One slice of a restoring divider as it travels down the pipeline.
  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [QuoW-1:0] low;
    logic [QuoW-1:0] quo;
    logic [DenW-1:0] den;
  } div_t;

  // Side information that rides along with the dividers.
  typedef struct packed {
    logic [ChanW-1:0] mx;
    logic             gray;
    logic             black;
  } side_t;

  // One restoring division step: shift in the next dividend bit, try a subtract.
  function automatic div_t div_step(input div_t s);
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    div_t          n;
    trial = {s.rem, s.low[QuoW-1]};
    diff  = trial - {1'b0, s.den};
    n     = s;
    n.low = {s.low[QuoW-2:0], 1'b0};
    if (trial >= {1'b0, s.den}) begin
      n.rem = diff[DenW-1:0];
      n.quo = {s.quo[QuoW-2:0], 1'b1};
    end else begin
      n.rem = trial[DenW-1:0];
      n.quo = {s.quo[QuoW-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

/* rtl/rgb_to_hsv_converter_top.sv */
// RGB to HSV converter: clamp, max/min, numerator setup, two pipelined dividers.
// Throughput: one pixel per clock; busy_o stays low, so start_i may be held high.
// The depth is set by the 17-stage restoring dividers for hue and saturation.
// Reset: rst_ni clears all valid bits at once; payload registers are not reset.
// The receiver cannot stall; each result is shown for exactly one cycle.
module rgb_to_hsv_converter_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [rgbhsv_pkg::InW-1:0]    red_in_i,
  input  logic signed [rgbhsv_pkg::InW-1:0]    green_in_i,
  input  logic signed [rgbhsv_pkg::InW-1:0]    blue_in_i,
  output logic                                 done_o,
  output logic        [rgbhsv_pkg::ChanW-1:0]  hue_o,
  output logic        [rgbhsv_pkg::ChanW-1:0]  saturation_o,
  output logic        [rgbhsv_pkg::ChanW-1:0]  brightness_o
);
  import rgbhsv_pkg::*;

  // The pipeline never stalls, so a new transaction is taken every cycle.
  assign busy_o = 1'b0;

  // Stage 0: clamp each channel to 0..65535.
  function automatic logic [ChanW-1:0] clamp(input logic [InW-1:0] x);
    logic [ChanW-1:0] c;
    if (x[InW-1]) begin
      c = '0;
    end else if (x[InW-2:ChanW] != '0) begin
      c = ChanMax;
    end else begin
      c = x[ChanW-1:0];
    end
    return c;
  endfunction

  logic             v0_q;
  logic [ChanW-1:0] r0_q, g0_q, b0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r0_q <= clamp(red_in_i);
    g0_q <= clamp(green_in_i);
    b0_q <= clamp(blue_in_i);
  end

  // Stage 1: max, min, spread and the hue numerator in sixths of a turn.
  logic             v1_q;
  logic [ChanW-1:0] mx1_d, mx1_q, mn1_d, d1_d, d1_q;
  logic [DenW-1:0]  num1_d, num1_q;
  logic [DenW-1:0]  d6_1;

  always_comb begin
    mx1_d = r0_q;
    if (g0_q > mx1_d) mx1_d = g0_q;
    if (b0_q > mx1_d) mx1_d = b0_q;
    mn1_d = r0_q;
    if (g0_q < mn1_d) mn1_d = g0_q;
    if (b0_q < mn1_d) mn1_d = b0_q;
    d1_d = mx1_d - mn1_d;
    d6_1 = {1'b0, d1_d, 2'b00} + {2'b00, d1_d, 1'b0};
    // Red wins ties, then green.
    if (mx1_d == r0_q) begin
      if (g0_q >= b0_q) begin
        num1_d = {3'b000, g0_q - b0_q};
      end else begin
        num1_d = d6_1 - {3'b000, b0_q - g0_q};
      end
    end else if (mx1_d == g0_q) begin
      num1_d = {2'b00, d1_d, 1'b0} + {3'b000, b0_q} - {3'b000, r0_q};
    end else begin
      num1_d = {1'b0, d1_d, 2'b00} + {3'b000, r0_q} - {3'b000, g0_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx1_q  <= mx1_d;
    d1_q   <= d1_d;
    num1_q <= num1_d;
  end

  // Stage 2: build both dividends and divisors and load the dividers.
  localparam int unsigned HueNW = DenW + ChanW;   // 35 bits
  localparam int unsigned SatNW = 2*ChanW + 1;    // 33 bits

  logic [HueNW-1:0] hue_n;
  logic [SatNW-1:0] sat_n;
  logic [ChanW+1:0] d3_2;
  div_t             hue_init, sat_init;
  side_t            side_init;

  always_comb begin
    d3_2  = {1'b0, d1_q, 1'b0} + {2'b00, d1_q};
    hue_n = {num1_q, {ChanW{1'b0}}} + HueNW'(d3_2);
    sat_n = ({d1_q, 17'b0} - SatNW'({d1_q, 1'b0})) + SatNW'(mx1_q);

    hue_init.rem = DenW'(hue_n[HueNW-1:QuoW]);
    hue_init.low = hue_n[QuoW-1:0];
    hue_init.quo = '0;
    hue_init.den = {d3_2, 1'b0};

    sat_init.rem = DenW'(sat_n[SatNW-1:QuoW]);
    sat_init.low = sat_n[QuoW-1:0];
    sat_init.quo = '0;
    sat_init.den = DenW'({mx1_q, 1'b0});

    side_init.mx    = mx1_q;
    side_init.gray  = (d1_q == '0);
    side_init.black = (mx1_q == '0);
  end

  // Divider pipeline: entry 0 is the loaded stage, one quotient bit per stage after.
  logic  [QuoW:0] vd_q;
  div_t           hue_q  [QuoW+1];
  div_t           sat_q  [QuoW+1];
  side_t          side_q [QuoW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= '0;
    end else begin
      vd_q <= {vd_q[QuoW-1:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q[0]  <= hue_init;
    sat_q[0]  <= sat_init;
    side_q[0] <= side_init;
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      hue_q[k]  <= div_step(hue_q[k-1]);
      sat_q[k]  <= div_step(sat_q[k-1]);
      side_q[k] <= side_q[k-1];
    end
  end

  // Output register: hue wraps modulo one turn; gray and black force zeros.
  logic             done_q;
  logic [ChanW-1:0] hue_out_q, sat_out_q, val_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vd_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_out_q <= side_q[QuoW].gray  ? '0 : hue_q[QuoW].quo[ChanW-1:0];
    sat_out_q <= side_q[QuoW].black ? '0 : sat_q[QuoW].quo[ChanW-1:0];
    val_out_q <= side_q[QuoW].mx;
  end

  assign done_o       = done_q;
  assign hue_o        = hue_out_q;
  assign saturation_o = sat_out_q;
  assign brightness_o = val_out_q;

  // Every result transaction comes from a start exactly one pipeline depth earlier.
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, QuoW + 4))
    else $error("result without a matching start");

  // A nonzero saturation needs a nonzero brightness.
  a_sat_needs_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturation_o != '0) |-> (brightness_o != '0))
    else $error("saturation set on a black pixel");

  // A nonzero hue implies a colored pixel, hence nonzero saturation.
  a_hue_needs_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hue_o != '0) |-> (saturation_o != '0))
    else $error("hue set on a gray pixel");

endmodule
